// ===== rtl/lavm_pkg.sv =====
// Shared types, index tables and saturation helper for the look-at view matrix block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lavm_pkg;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][32:0] vec33_t;
  typedef logic [2:0][63:0] vec64_t;

  typedef struct packed {
    vec32_t eye;
    vec33_t dif;
    vec32_t up;
    logic   dif_zero;
  } job_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_rsp_t;

  localparam int unsigned ROOT_STEPS = 32;

  function automatic logic [1:0] cross_a(input logic [3:0] j);
    logic [1:0] r;
    unique case (j)
      4'd0: r = 2'd1;
      4'd1: r = 2'd2;
      4'd2: r = 2'd2;
      4'd3: r = 2'd0;
      4'd4: r = 2'd0;
      4'd5: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_b(input logic [3:0] j);
    logic [1:0] r;
    unique case (j)
      4'd0: r = 2'd2;
      4'd1: r = 2'd1;
      4'd2: r = 2'd0;
      4'd3: r = 2'd2;
      4'd4: r = 2'd1;
      4'd5: r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] dot_row(input logic [3:0] j);
    logic [1:0] r;
    if (j < 4'd3) begin
      r = 2'd0;
    end else if (j < 4'd6) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [1:0] dot_col(input logic [3:0] j);
    logic [1:0] r;
    unique case (j)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      4'd2, 4'd5, 4'd8: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if ((&v[65:31]) || !(|v[65:31])) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== rtl/look_at_view_matrix.sv =====
// Top level of the look-at view matrix block: intake, job queue and compute engine.
// Depends on lavm_pkg, lavm_front, lavm_fifo, lavm_back and lavm_norm.
//
//   channel  direction  handshake              word
//   in       input      in_valid_i/in_stall_o  eye, center, up (Q16.16 each)
//   out      output     out_valid_o/out_stall_i one matrix row, four per input
//
// The normalizer runs a power-of-two prescale, 32 square-root steps and FRAC_BITS + 1
// division steps, once for z (skipped when eye equals center) and once for x.
// The queue holds two words ahead.
// Reset clears all control state at once; no clearing pass is needed.
// A stalled output holds its row while the engine goes on with the next word.
`timescale 1ns / 1ps

module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  input  logic [31:0] eye_z_i,
  input  logic [31:0] center_x_i,
  input  logic [31:0] center_y_i,
  input  logic [31:0] center_z_i,
  input  logic [31:0] up_x_i,
  input  logic [31:0] up_y_i,
  input  logic [31:0] up_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  row_index_o,
  output logic [31:0] elem0_o,
  output logic [31:0] elem1_o,
  output logic [31:0] elem2_o,
  output logic [31:0] elem3_o,
  output logic        last_row_o,
  output logic        degenerate_o
);
  import lavm_pkg::*;

  job_t push_job, pop_job;
  logic push, full, pop, qvalid;

  lavm_front u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .eye_x_i   (eye_x_i),
    .eye_y_i   (eye_y_i),
    .eye_z_i   (eye_z_i),
    .center_x_i(center_x_i),
    .center_y_i(center_y_i),
    .center_z_i(center_z_i),
    .up_x_i    (up_x_i),
    .up_y_i    (up_y_i),
    .up_z_i    (up_z_i),
    .full_i    (full),
    .push_o    (push),
    .job_o     (push_job)
  );

  lavm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(qvalid),
    .data_o (pop_job)
  );

  lavm_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qvalid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .elem0_o     (elem0_o),
    .elem1_o     (elem1_o),
    .elem2_o     (elem2_o),
    .elem3_o     (elem3_o),
    .last_row_o  (last_row_o),
    .degenerate_o(degenerate_o)
  );

endmodule

// ===== rtl/lavm_fifo.sv =====
// Two-entry queue of jobs between the intake side and the compute engine.
// Depends on lavm_pkg for the job type.
`timescale 1ns / 1ps

module lavm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lavm_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lavm_pkg::job_t data_o
);
  import lavm_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/lavm_front.sv =====
// Intake side: takes an input word, forms eye minus center and flags a zero view direction.
// Depends on lavm_pkg; feeds lavm_fifo.
`timescale 1ns / 1ps

module lavm_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [31:0]   eye_x_i,
  input  logic [31:0]   eye_y_i,
  input  logic [31:0]   eye_z_i,
  input  logic [31:0]   center_x_i,
  input  logic [31:0]   center_y_i,
  input  logic [31:0]   center_z_i,
  input  logic [31:0]   up_x_i,
  input  logic [31:0]   up_y_i,
  input  logic [31:0]   up_z_i,
  input  logic          full_i,
  output logic          push_o,
  output lavm_pkg::job_t job_o
);
  import lavm_pkg::*;

  vec32_t eye, ctr;

  assign eye = {eye_z_i, eye_y_i, eye_x_i};
  assign ctr = {center_z_i, center_y_i, center_x_i};

  always_comb begin
    job_o.eye = eye;
    job_o.up  = {up_z_i, up_y_i, up_x_i};
    for (int i = 0; i < 3; i++) begin
      job_o.dif[i] = {eye[i][31], eye[i]} - {ctr[i][31], ctr[i]};
    end
    job_o.dif_zero = (job_o.dif == '0);
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ===== rtl/lavm_norm.sv =====
// Vector normalization unit: power-of-two prescale, sum of squares, bit-serial
// square root and three long-division lanes. Depends on lavm_pkg.
`timescale 1ns / 1ps

module lavm_norm #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  lavm_pkg::vec64_t   vec_i,
  output lavm_pkg::norm_rsp_t rsp_o,
  output lavm_pkg::vec32_t   unit_o
);
  import lavm_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SCALE = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_ROOT  = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;

  logic [2:0]  st_q;
  logic [4:0]  cnt_q;
  logic        done_q, zero_q;
  vec64_t      mag_q;
  logic [2:0]  neg_q;
  logic [63:0] mx_q, sum_q, rem_q, root_q, bit_q, dvs_q;
  vec64_t      drem_q;
  logic [2:0][QW-1:0] quo_q;
  vec32_t      unit_q;

  vec64_t      mag_in;
  logic [63:0] mx_in;
  logic [61:0] sq;
  logic [63:0] rt_try, root_nx, rem_nx;
  logic [2:0]  ge;
  logic [2:0][QW-1:0] quo_nx;

  always_comb begin
    mx_in = '0;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec_i[i][63] ? (64'd0 - vec_i[i]) : vec_i[i];
      if (mag_in[i] > mx_in) begin
        mx_in = mag_in[i];
      end
    end
  end

  assign sq     = mag_q[cnt_q[1:0]][30:0] * mag_q[cnt_q[1:0]][30:0];
  assign rt_try = root_q + bit_q;

  always_comb begin
    if (rem_q >= rt_try) begin
      rem_nx  = rem_q - rt_try;
      root_nx = (root_q >> 1) + bit_q;
    end else begin
      rem_nx  = rem_q;
      root_nx = root_q >> 1;
    end
    for (int i = 0; i < 3; i++) begin
      ge[i]     = (drem_q[i] >= dvs_q);
      quo_nx[i] = {quo_q[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        N_IDLE: begin
          if (start_i) begin
            if (mx_in == '0) begin
              done_q <= 1'b1;
            end else begin
              st_q <= N_SCALE;
            end
          end
        end
        N_SCALE: begin
          if ((mx_q[63:31] == '0) && (mx_q[63:22] != '0) && mx_q[30]) begin
            st_q  <= N_SQ;
            cnt_q <= '0;
          end
        end
        N_SQ: begin
          if (cnt_q == 5'd2) begin
            st_q  <= N_ROOT;
            cnt_q <= '0;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        N_ROOT: begin
          if (cnt_q == 5'(ROOT_STEPS - 1)) begin
            st_q  <= N_DIV;
            cnt_q <= 5'(QW - 1);
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        N_DIV: begin
          if (cnt_q == '0) begin
            st_q   <= N_IDLE;
            done_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        default: st_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      N_IDLE: begin
        if (start_i) begin
          mag_q  <= mag_in;
          mx_q   <= mx_in;
          zero_q <= (mx_in == '0);
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][63];
          end
          if (mx_in == '0) begin
            unit_q <= '0;
          end
        end
      end
      N_SCALE: begin
        sum_q <= '0;
        if (mx_q[63:39] != '0) begin
          mx_q <= mx_q >> 8;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 8;
        end else if (mx_q[63:31] != '0) begin
          mx_q <= mx_q >> 1;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (mx_q[63:22] == '0) begin
          mx_q <= mx_q << 8;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 8;
        end else if (!mx_q[30]) begin
          mx_q <= mx_q << 1;
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end
      end
      N_SQ: begin
        sum_q  <= sum_q + {2'b00, sq};
        rem_q  <= sum_q + {2'b00, sq};
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      N_ROOT: begin
        rem_q  <= rem_nx;
        root_q <= root_nx;
        bit_q  <= bit_q >> 2;
        dvs_q  <= root_nx << (QW - 1);
        for (int i = 0; i < 3; i++) begin
          drem_q[i] <= (mag_q[i] << FRAC_BITS) + (root_nx >> 1);
          quo_q[i]  <= '0;
        end
      end
      N_DIV: begin
        dvs_q <= dvs_q >> 1;
        for (int i = 0; i < 3; i++) begin
          if (ge[i]) begin
            drem_q[i] <= drem_q[i] - dvs_q;
          end
          quo_q[i] <= quo_nx[i];
          if (cnt_q == '0) begin
            unit_q[i] <= neg_q[i] ? (32'd0 - {{(32 - QW){1'b0}}, quo_nx[i]})
                                  : {{(32 - QW){1'b0}}, quo_nx[i]};
          end
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = zero_q;
  assign unit_o     = unit_q;

endmodule

// ===== rtl/lavm_back.sv =====
// Compute engine: sequences the normalizer, one shared multiplier for the cross
// and dot products, and a row output register. Depends on lavm_pkg and lavm_norm.
`timescale 1ns / 1ps

module lavm_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  lavm_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    row_index_o,
  output logic [31:0]   elem0_o,
  output logic [31:0]   elem1_o,
  output logic [31:0]   elem2_o,
  output logic [31:0]   elem3_o,
  output logic          last_row_o,
  output logic          degenerate_o
);
  import lavm_pkg::*;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_WZ    = 4'd1;
  localparam logic [3:0] B_CROSS = 4'd2;
  localparam logic [3:0] B_SX    = 4'd3;
  localparam logic [3:0] B_WX    = 4'd4;
  localparam logic [3:0] B_YMUL  = 4'd5;
  localparam logic [3:0] B_YRND  = 4'd6;
  localparam logic [3:0] B_DOT   = 4'd7;
  localparam logic [3:0] B_FIN   = 4'd8;

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  logic [3:0]  st_q, cnt_q;
  logic        nstart_q, degen_q;
  vec64_t      nvec_q;
  vec32_t      eye_q, up_q, z_q, x_q;
  logic [2:0][33:0] y_q;
  logic [2:0][65:0] acc_q;

  logic        em_valid_q, em_degen_q;
  logic [1:0]  em_row_q;
  logic [2:0][3:0][31:0] em_el_q;

  norm_rsp_t   nrsp;
  vec32_t      nunit;

  logic [1:0]  ca, cb, dr, dc;
  logic signed [33:0] ma;
  logic signed [31:0] mb;
  logic signed [65:0] prod;
  logic        out_acc, em_free;
  logic [2:0][65:0] trn;
  logic [2:0][65:0] axw;

  lavm_norm #(
    .FRAC_BITS(FRAC_BITS)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(nstart_q),
    .vec_i  (nvec_q),
    .rsp_o  (nrsp),
    .unit_o (nunit)
  );

  assign ca = cross_a(cnt_q);
  assign cb = cross_b(cnt_q);
  assign dr = dot_row(cnt_q);
  assign dc = dot_col(cnt_q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_q)
      B_CROSS: begin
        ma = {{2{z_q[cb][31]}}, z_q[cb]};
        mb = up_q[ca];
      end
      B_YMUL: begin
        ma = {{2{x_q[cb][31]}}, x_q[cb]};
        mb = z_q[ca];
      end
      B_DOT: begin
        mb = eye_q[dc];
        unique case (dr)
          2'd0: ma = {{2{x_q[dc][31]}}, x_q[dc]};
          2'd1: ma = y_q[dc];
          default: ma = {{2{z_q[dc][31]}}, z_q[dc]};
        endcase
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      trn[r] = ($signed(66'd0 - acc_q[r]) + HALF) >>> FRAC_BITS;
      axw[r] = {{34{x_q[r][31]}}, x_q[r]};
    end
  end

  assign out_acc   = em_valid_q && !out_stall_i;
  assign em_free   = !em_valid_q || (out_acc && (em_row_q == 2'd3));
  assign job_pop_o = (st_q == B_IDLE) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= B_IDLE;
      cnt_q      <= '0;
      nstart_q   <= 1'b0;
      em_valid_q <= 1'b0;
      em_row_q   <= '0;
    end else begin
      nstart_q <= 1'b0;
      unique case (st_q)
        B_IDLE: begin
          if (job_valid_i) begin
            cnt_q <= '0;
            if (job_i.dif_zero) begin
              st_q <= B_CROSS;
            end else begin
              st_q     <= B_WZ;
              nstart_q <= 1'b1;
            end
          end
        end
        B_WZ: begin
          if (nrsp.done) begin
            st_q  <= B_CROSS;
            cnt_q <= '0;
          end
        end
        B_CROSS: begin
          if (cnt_q == 4'd5) begin
            st_q <= B_SX;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        B_SX: begin
          st_q     <= B_WX;
          nstart_q <= 1'b1;
        end
        B_WX: begin
          if (nrsp.done) begin
            st_q  <= B_YMUL;
            cnt_q <= '0;
          end
        end
        B_YMUL: begin
          if (cnt_q == 4'd5) begin
            st_q <= B_YRND;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        B_YRND: begin
          st_q  <= B_DOT;
          cnt_q <= '0;
        end
        B_DOT: begin
          if (cnt_q == 4'd8) begin
            st_q <= B_FIN;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        B_FIN: begin
          if (em_free) begin
            st_q <= B_IDLE;
          end
        end
        default: st_q <= B_IDLE;
      endcase

      if ((st_q == B_FIN) && em_free) begin
        em_valid_q <= 1'b1;
        em_row_q   <= '0;
      end else if (out_acc) begin
        if (em_row_q == 2'd3) begin
          em_valid_q <= 1'b0;
        end else begin
          em_row_q <= em_row_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      B_IDLE: begin
        if (job_valid_i) begin
          eye_q   <= job_i.eye;
          up_q    <= job_i.up;
          degen_q <= job_i.dif_zero;
          if (job_i.dif_zero) begin
            z_q <= '0;
          end
          for (int i = 0; i < 3; i++) begin
            nvec_q[i] <= {{31{job_i.dif[i][32]}}, job_i.dif[i]};
          end
        end
      end
      B_WZ: begin
        if (nrsp.done) begin
          z_q     <= nunit;
          degen_q <= degen_q | nrsp.zero;
        end
      end
      B_CROSS, B_YMUL: begin
        if (!cnt_q[0]) begin
          acc_q[cnt_q[2:1]] <= prod;
        end else begin
          acc_q[cnt_q[2:1]] <= acc_q[cnt_q[2:1]] - prod;
        end
      end
      B_SX: begin
        for (int i = 0; i < 3; i++) begin
          nvec_q[i] <= acc_q[i][63:0];
        end
      end
      B_WX: begin
        if (nrsp.done) begin
          x_q     <= nunit;
          degen_q <= degen_q | nrsp.zero;
        end
      end
      B_YRND: begin
        for (int i = 0; i < 3; i++) begin
          y_q[i]   <= 34'(($signed(acc_q[i]) + HALF) >>> FRAC_BITS);
          acc_q[i] <= '0;
        end
      end
      B_DOT: begin
        acc_q[dr] <= acc_q[dr] + prod;
      end
      B_FIN: begin
        if (em_free) begin
          em_degen_q <= degen_q;
          for (int c = 0; c < 3; c++) begin
            em_el_q[0][c] <= sat32(axw[c]);
            em_el_q[1][c] <= sat32({{32{y_q[c][33]}}, y_q[c]});
            em_el_q[2][c] <= z_q[c];
          end
          for (int r = 0; r < 3; r++) begin
            em_el_q[r][3] <= sat32(trn[r]);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (em_row_q == 2'd3) begin
      elem0_o = '0;
      elem1_o = '0;
      elem2_o = '0;
      elem3_o = ONE;
    end else begin
      elem0_o = em_el_q[em_row_q][0];
      elem1_o = em_el_q[em_row_q][1];
      elem2_o = em_el_q[em_row_q][2];
      elem3_o = em_el_q[em_row_q][3];
    end
  end

  assign out_valid_o  = em_valid_q;
  assign row_index_o  = em_row_q;
  assign last_row_o   = (em_row_q == 2'd3);
  assign degenerate_o = em_degen_q;

  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && (em_row_q != 2'd3)) |=> (em_row_q == $past(em_row_q) + 2'd1))
    else $error("row index did not advance after a delivered row");

  a_degen_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && (em_row_q != 2'd3)) |=> (em_degen_q == $past(em_degen_q)))
    else $error("degenerate flag changed within one matrix");

  a_start_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nstart_q |-> ((st_q == B_WZ) || (st_q == B_WX)))
    else $error("normalizer started outside a wait state");

  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrsp.done |-> ((st_q == B_WZ) || (st_q == B_WX)))
    else $error("normalizer finished while nobody waited");

endmodule
